FILE: hw/rtl/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants for the binary search table
// default table depth, index width helper, sequencer states, step status
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int DEPTH_DEF = 1024;

    // width of the internal signed bound registers: holds -1, the largest
    // table index and the largest window index, plus room for low + high
    function automatic int bst_xw(input int depth);
        int aw;
        begin
            aw = $clog2(depth);
            bst_xw = ((aw > 10) ? aw : 10) + 2;
        end
    endfunction

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic done;
        logic found;
    } step_t;

endpackage

FILE: hw/rtl/bst_table.sv
// ----------------------------------------------------------------------------
// bst_table: table storage
// single write port, single read port with registered read data
// ----------------------------------------------------------------------------
module bst_table #(
    parameter int DEPTH = bst_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(bst_pkg::DEPTH_DEF)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic signed [31:0]   wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic signed [31:0]   rd_data
);
    import bst_pkg::*;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/bst_step.sv
// ----------------------------------------------------------------------------
// bst_step: one probe of the search
// compares the entry read at mid with the key and narrows the window
// ----------------------------------------------------------------------------
module bst_step #(
    parameter int XW = bst_pkg::bst_xw(bst_pkg::DEPTH_DEF)
) (
    input  logic signed [XW-1:0] mid,
    input  logic signed [31:0]   entry,
    input  logic signed [31:0]   key,
    input  logic signed [XW-1:0] lo,
    input  logic signed [XW-1:0] hi,
    output logic signed [XW-1:0] lo_out,
    output logic signed [XW-1:0] hi_out,
    output logic signed [XW-1:0] mid_out,
    output bst_pkg::step_t       status
);
    import bst_pkg::*;

    logic signed [XW-1:0] sum;

    always_comb begin
        lo_out = lo;
        hi_out = hi;
        status = '0;
        if (entry == key) begin
            status.done  = 1'b1;
            status.found = 1'b1;
        end else if (entry < key) begin
            lo_out = mid + XW'(1);
        end else begin
            hi_out = mid - XW'(1);
        end
        if (!status.done && (lo_out > hi_out)) begin
            status.done = 1'b1;
        end
    end

    // both bounds are non-negative while the window is open
    assign sum     = lo_out + hi_out;
    assign mid_out = sum >>> 1;

endmodule

FILE: hw/rtl/binary_search_table_unit.sv
// ----------------------------------------------------------------------------
// binary_search_table_unit: sorted table lookup by binary search
// search: the probes run one per cycle (at most log2(DEPTH)+1, eleven for
//   1024 entries), then the result is handed to the output register
// input: write words are taken back to back; a search holds off the input
//   for all its probes, since they share the single table read port, and
//   until its result enters the output register, longer while m_ready is low
// reset: synchronous active-low aresetn clears the sequencer and output valid;
//   table contents are undefined until written
// ----------------------------------------------------------------------------
module binary_search_table_unit #(
    parameter int DEPTH = bst_pkg::DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input words
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [9:0]          s_entry_index,
    input  logic signed [31:0]  s_entry_value,
    input  logic [9:0]          s_low_index,
    input  logic signed [10:0]  s_high_index,
    input  logic signed [31:0]  s_search_key,
    // result words
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [9:0]          m_position
);
    import bst_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int XW = bst_xw(DEPTH);
    localparam logic signed [XW-1:0] HI_MAX = XW'(DEPTH - 1);

    // sequencer state
    state_t state_reg, state_next;

    // search window, probe point and key
    logic signed [XW-1:0] lo_reg, lo_next;
    logic signed [XW-1:0] hi_reg, hi_next;
    logic signed [XW-1:0] mid_reg, mid_next;
    logic signed [31:0]   key_reg, key_next;

    // finished search waiting for the output register
    logic       res_found_reg, res_found_next;
    logic [9:0] res_pos_reg, res_pos_next;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic       m_found_reg, m_found_next;
    logic [9:0] m_position_reg, m_position_next;

    // input word decode
    logic                 s_accept;
    logic signed [XW-1:0] in_lo;
    logic signed [XW-1:0] in_hi;
    logic signed [XW-1:0] in_sum;
    logic signed [XW-1:0] in_mid;
    logic [XW-1:0]        wr_idx;
    logic                 wr_en;

    // table port and probe unit
    logic signed [31:0]   rd_data;
    logic signed [XW-1:0] step_lo;
    logic signed [XW-1:0] step_hi;
    logic signed [XW-1:0] step_mid;
    step_t                step_status;
    logic                 out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // window bounds: high index saturates to the last table entry
    assign in_lo = XW'(s_low_index);
    always_comb begin
        in_hi = XW'(s_high_index);
        if (in_hi > HI_MAX) begin
            in_hi = HI_MAX;
        end
    end
    assign in_sum = in_lo + in_hi;
    assign in_mid = in_sum >>> 1;

    // writes beyond the table are dropped
    assign wr_idx = XW'(s_entry_index);
    assign wr_en  = s_accept && !s_action && (wr_idx < XW'(DEPTH));

    bst_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx[AW-1:0]),
        .wr_data (s_entry_value),
        .rd_addr (mid_next[AW-1:0]),
        .rd_data (rd_data)
    );

    bst_step #(
        .XW (XW)
    ) u_step (
        .mid     (mid_reg),
        .entry   (rd_data),
        .key     (key_reg),
        .lo      (lo_reg),
        .hi      (hi_reg),
        .lo_out  (step_lo),
        .hi_out  (step_hi),
        .mid_out (step_mid),
        .status  (step_status)
    );

    // output register can take a word when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        key_reg        <= key_next;
        res_found_reg  <= res_found_next;
        res_pos_reg    <= res_pos_next;
        m_found_reg    <= m_found_next;
        m_position_reg <= m_position_next;
    end

    always_comb begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        key_next        = key_reg;
        res_found_next  = res_found_reg;
        res_pos_next    = res_pos_reg;
        m_valid_next    = m_valid_reg;
        m_found_next    = m_found_reg;
        m_position_next = m_position_reg;

        // drain the output word
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                // first probe address goes to the table on the accept edge
                mid_next = in_mid;
                if (s_accept && s_action) begin
                    lo_next  = in_lo;
                    hi_next  = in_hi;
                    key_next = s_search_key;
                    if (in_lo > in_hi) begin
                        // empty window
                        res_found_next = 1'b0;
                        res_pos_next   = '0;
                        state_next     = ST_FINISH;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // entry at mid_reg is on rd_data this cycle
                lo_next  = step_lo;
                hi_next  = step_hi;
                mid_next = step_mid;
                if (step_status.done) begin
                    res_found_next = step_status.found;
                    res_pos_next   = step_status.found ? mid_reg[9:0] : 10'd0;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_found_next    = res_found_reg;
                    m_position_next = res_pos_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_position_reg;

endmodule

FILE: sim/tb_binary_search_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_search_table_unit: self-checking bench for the search table
// loads sorted runs of entries through write words and checks every search
// result against a typed value or a bit-exact lookup on a table mirror;
// directed rows come first, then random sequences under several idle mixes
// ----------------------------------------------------------------------------
module tb_binary_search_table_unit;

    localparam int DEPTH          = bst_pkg::DEPTH_DEF;
    localparam int RANDOM_WORDS   = 1130;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;

    // word kinds on the input channel
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    localparam logic signed [31:0] VAL_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN     = 32'sh8000_0000;
    localparam logic [10:0]        HI_EMPTY    = 11'h7FF;    // -1
    localparam logic [10:0]        HI_MOST_NEG = 11'h400;    // -1024

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_NONE,
        CHK_TYPED,
        CHK_MODEL
    } check_t;

    typedef struct packed {
        logic       found;
        logic [9:0] position;
    } result_t;

    typedef struct {
        logic        action;
        logic [9:0]  eidx;
        logic [31:0] evalue;
        logic [9:0]  lo;
        logic [10:0] hi;
        logic [31:0] key;
        check_t      chk;
        result_t     typed;
    } directed_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_action;
    logic [9:0]         s_entry_index;
    logic signed [31:0] s_entry_value;
    logic [9:0]         s_low_index;
    logic signed [10:0] s_high_index;
    logic signed [31:0] s_search_key;
    logic               m_valid;
    logic               m_ready;
    logic               m_found;
    logic [9:0]         m_position;

    // mirror of the table and which entries hold a written value
    logic signed [31:0] entry_mirror [0:DEPTH-1];
    bit                 entry_written [0:DEPTH-1];

    result_t       pending_results [$];
    directed_row_t directed_rows [$];

    int mismatch_count = 0;
    int words_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;

    binary_search_table_unit #(
        .DEPTH(DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .s_low_index   (s_low_index),
        .s_high_index  (s_high_index),
        .s_search_key  (s_search_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_position    (m_position)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // bit-exact binary search over the mirror; flags any probe that lands
    // on an entry never written since reset
    function automatic result_t lookup_key(input logic [9:0] lo_in,
                                           input logic [10:0] hi_in,
                                           input logic signed [31:0] key,
                                           output bit reads_unwritten);
        int      lo;
        int      hi;
        int      mid;
        result_t res;
        lo = lo_in;
        hi = $signed(hi_in);
        res = '0;
        reads_unwritten = 1'b0;
        // a bound past the table end saturates to the last entry
        if (hi > DEPTH - 1) hi = DEPTH - 1;
        while (lo <= hi && !res.found) begin
            mid = (lo + hi) / 2;
            if (!entry_written[mid]) reads_unwritten = 1'b1;
            if (entry_mirror[mid] == key) begin
                res.found    = 1'b1;
                res.position = mid[9:0];
            end else if (entry_mirror[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return res;
    endfunction

    // offer one word, hold it until accepted, then update the mirror or
    // queue the result this search must produce
    task automatic send_word(input logic action, input logic [9:0] eidx,
                             input logic [31:0] evalue, input logic [9:0] lo,
                             input logic [10:0] hi, input logic [31:0] key,
                             input check_t chk, input result_t typed);
        bit      unused_flag;
        result_t want;
        // random gap before the word, valid low the whole time
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_action      <= action;
        s_entry_index <= eidx;
        s_entry_value <= evalue;
        s_low_index   <= lo;
        s_high_index  <= hi;
        s_search_key  <= key;
        do @(posedge aclk); while (s_ready !== 1'b1);
        words_sent++;
        if (action == ACT_WRITE) begin
            entry_mirror[eidx]  = evalue;
            entry_written[eidx] = 1'b1;
        end else begin
            want = lookup_key(lo, hi, key, unused_flag);
            pending_results.push_back((chk == CHK_TYPED) ? typed : want);
        end
    endtask

    task automatic send_write(input logic [9:0] idx, input logic [31:0] value);
        send_word(ACT_WRITE, idx, value, 10'($urandom), 11'($urandom), $urandom,
                  CHK_NONE, '0);
    endtask

    // a window whose probes would touch an unwritten entry is swapped for
    // an empty one (high just below low), which reads nothing
    task automatic send_search(input logic [9:0] lo, input logic [10:0] hi,
                               input logic [31:0] key);
        bit bad;
        void'(lookup_key(lo, hi, key, bad));
        if (bad) hi = {1'b0, lo} - 11'd1;
        send_word(ACT_SEARCH, 10'($urandom), $urandom, lo, hi, key, CHK_MODEL, '0);
    endtask

    // write a sorted run at a random base, then search it: mostly hits,
    // some near misses, some random keys, full or partial windows
    task automatic load_and_search(input int n_search, input bit with_hold);
        int                 base;
        int                 n;
        int                 i;
        int                 k;
        int                 pick;
        int                 lo;
        int                 hi;
        longint             cur;
        logic signed [31:0] vals [0:23];
        logic [31:0]        key;
        base = $urandom_range(DEPTH - 1);
        n    = $urandom_range(24, 1);
        if (base + n > DEPTH) n = DEPTH - base;
        cur = ($urandom_range(9) == 0) ? longint'(VAL_MIN) : longint'($signed($urandom));
        k   = $urandom_range(30);
        for (i = 0; i < n; i++) begin
            vals[i] = cur[31:0];
            send_write(10'(base + i), vals[i]);
            cur = cur + $urandom_range(1 << k);
            if (cur > 2147483647) cur = 2147483647;
        end
        // receiver holds off while searches keep coming, filling the block
        if (with_hold) hold_req <= hold_req + 1;
        for (i = 0; i < n_search; i++) begin
            pick = $urandom_range(n - 1);
            case ($urandom_range(3))
                0, 1: key = vals[pick];
                2: key = $urandom_range(1) ? vals[pick] + 32'd1 : vals[pick] - 32'd1;
                default: key = $urandom;
            endcase
            if ($urandom_range(9) < 7) begin
                lo = base;
                hi = base + n - 1;
            end else begin
                lo = base + $urandom_range(n - 1);
                hi = lo + $urandom_range(base + n - 1 - lo);
            end
            send_search(10'(lo), 11'(hi), key);
        end
    endtask

    task automatic add_row(input logic action, input logic [9:0] eidx,
                           input logic [31:0] evalue, input logic [9:0] lo,
                           input logic [10:0] hi, input logic [31:0] key,
                           input check_t chk, input logic efound,
                           input logic [9:0] epos);
        directed_row_t row;
        row.action         = action;
        row.eidx           = eidx;
        row.evalue         = evalue;
        row.lo             = lo;
        row.hi             = hi;
        row.key            = key;
        row.chk            = chk;
        row.typed.found    = efound;
        row.typed.position = epos;
        directed_rows.push_back(row);
    endtask

    // result channel ready: random stalls per phase, or one long hold-off
    // counted here whenever the stimulus asks for it
    initial begin
        int hold_seen;
        hold_seen = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result word: found=%0b position=%0d",
                             m_found, m_position);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_found !== want.found || m_position !== want.position) begin
                    if (mismatch_count < 10)
                        $display("mismatch: exp found=%0b pos=%0d, got found=%0b pos=%0d",
                                 want.found, want.position, m_found, m_position);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too many cycles in a row without any handshake
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) ||
                (m_valid === 1'b1 && m_ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        int p;
        int i;
        int phase_end;
        int send_pct [0:3];
        int stall_pct [0:3];
        send_pct  = '{0, 61, 0, 10};
        stall_pct = '{0, 0, 61, 10};

        for (i = 0; i < DEPTH; i++) begin
            entry_mirror[i]  = '0;
            entry_written[i] = 1'b0;
        end

        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_action      <= ACT_WRITE;
        s_entry_index <= '0;
        s_entry_value <= '0;
        s_low_index   <= '0;
        s_high_index  <= '0;
        s_search_key  <= '0;

        // empty windows straight after reset: nothing is read
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd0, HI_EMPTY, 32'd0, CHK_TYPED, 1'b0, 10'd0);
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd1023, HI_MOST_NEG, VAL_MAX,
                CHK_TYPED, 1'b0, 10'd0);
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd5, 11'd4, 32'd7, CHK_TYPED, 1'b0, 10'd0);
        // sorted run with both value extremes; search fields are don't-care
        add_row(ACT_WRITE, 10'd0, VAL_MIN, 10'd1023, 11'd1023, 32'h5A5A_5A5A,
                CHK_NONE, 1'b0, 10'd0);
        add_row(ACT_WRITE, 10'd1, -32'sd5, 10'd0, HI_EMPTY, VAL_MAX, CHK_NONE, 1'b0, 10'd0);
        add_row(ACT_WRITE, 10'd2, 32'd0, 10'd512, 11'd3, VAL_MIN, CHK_NONE, 1'b0, 10'd0);
        add_row(ACT_WRITE, 10'd3, 32'd7, 10'd0, 11'd0, 32'd0, CHK_NONE, 1'b0, 10'd0);
        add_row(ACT_WRITE, 10'd4, VAL_MAX, 10'd0, 11'd0, 32'd0, CHK_NONE, 1'b0, 10'd0);
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd0, 11'd4, VAL_MIN, CHK_TYPED, 1'b1, 10'd0);
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd0, 11'd4, VAL_MAX, CHK_TYPED, 1'b1, 10'd4);
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd0, 11'd4, 32'd3, CHK_TYPED, 1'b0, 10'd0);
        // write fields on a search word are don't-care
        add_row(ACT_SEARCH, 10'h3FF, 32'hFFFF_FFFF, 10'd0, 11'd4, 32'd7,
                CHK_MODEL, 1'b0, 10'd0);
        add_row(ACT_SEARCH, 10'h2AA, VAL_MAX, 10'd0, 11'd4, -32'sd5, CHK_MODEL, 1'b0, 10'd0);
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd2, 11'd2, 32'd0, CHK_TYPED, 1'b1, 10'd2);
        // unsorted window at the top of the table
        add_row(ACT_WRITE, 10'd1020, 32'd50, 10'd0, 11'd0, 32'd0, CHK_NONE, 1'b0, 10'd0);
        add_row(ACT_WRITE, 10'd1021, 32'd200, 10'd0, 11'd0, 32'd0, CHK_NONE, 1'b0, 10'd0);
        add_row(ACT_WRITE, 10'd1022, 32'd100, 10'd0, 11'd0, 32'd0, CHK_NONE, 1'b0, 10'd0);
        add_row(ACT_WRITE, 10'd1023, VAL_MAX, 10'd0, 11'd0, 32'd0, CHK_NONE, 1'b0, 10'd0);
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd1020, 11'd1023, 32'd200, CHK_MODEL, 1'b0, 10'd0);
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd1020, 11'd1023, 32'd10, CHK_MODEL, 1'b0, 10'd0);
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd1020, 11'd1023, VAL_MAX, CHK_MODEL, 1'b0, 10'd0);
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd1023, 11'd1023, VAL_MAX,
                CHK_TYPED, 1'b1, 10'd1023);
        // overwrite an entry, then search across it
        add_row(ACT_WRITE, 10'd2, 32'd1, 10'd0, 11'd0, 32'd0, CHK_NONE, 1'b0, 10'd0);
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd0, 11'd4, 32'd0, CHK_MODEL, 1'b0, 10'd0);
        add_row(ACT_SEARCH, 10'd0, 32'd0, 10'd0, 11'd4, 32'd1, CHK_MODEL, 1'b0, 10'd0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, no idling
        foreach (directed_rows[r])
            send_word(directed_rows[r].action, directed_rows[r].eidx,
                      directed_rows[r].evalue, directed_rows[r].lo,
                      directed_rows[r].hi, directed_rows[r].key,
                      directed_rows[r].chk, directed_rows[r].typed);

        // random part, one idle mix per phase
        phase_end = words_sent;
        for (p = 0; p < 4; p++) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct <= stall_pct[p];
            phase_end += RANDOM_WORDS / 4;
            // long receiver hold-off with back-to-back searches
            if (p == 0) load_and_search(12, 1'b1);
            while (words_sent < phase_end) begin
                i = $urandom_range(99);
                if (i < 55)
                    load_and_search($urandom_range(6, 1), 1'b0);
                else if (i < 75)
                    send_search(10'($urandom), 11'($urandom), $urandom);
                else if (i < 90)
                    send_write(10'($urandom), $urandom);
                else
                    send_search(10'($urandom), 11'(-int'($urandom_range(1024, 1))),
                                $urandom);
            end
        end
        s_valid <= 1'b0;

        // drain outstanding results, then allow a search's worth of cycles
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
